// File: rtl/assert_macros.svh
// Assertion macros used by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/icu_pkg.sv
// Types, constants and helpers of the inode reference cache.
package icu_pkg;

  localparam int SLOTS    = 32;
  localparam int REF_BITS = 16;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W   = 5;
  localparam int DEV_W    = 8;
  localparam int INO_W    = 32;
  localparam int ACT_W    = 3;

  localparam logic [REF_BITS-1:0] REF_MAX  = '1;
  localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);
  localparam logic [REF_BITS-1:0] REF_ZERO = '0;
  localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_GET    = 3'd0,
    ACT_DUP    = 3'd1,
    ACT_PUT    = 3'd2,
    ACT_LOCK   = 3'd3,
    ACT_UNLOCK = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BUSY     = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SCAN,
    SQ_READ,
    SQ_CAP,
    SQ_EXEC
  } seq_state_e;

  typedef struct packed {
    logic [REF_BITS-1:0] refcnt;
    logic [DEV_W-1:0]    device;
    logic [INO_W-1:0]    inode;
    logic                valid;
    logic                busy;
  } entry_t;

  // Raw action code: codes past the enum members are legal and ignored.
  // Members run from the top bits down, so action lands in the lowest bits.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [INO_W-1:0]  inode;
    logic [DEV_W-1:0]  device;
    logic [ACT_W-1:0]  action;
  } req_t;

  typedef struct packed {
    logic found;
    logic free_seen;
  } scan_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } wr_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] result_slot;
    logic              hit;
    logic              load_request;
    logic              writeback_request;
    logic              wake;
    logic [DEV_W-1:0]  slot_device;
    logic [INO_W-1:0]  slot_inode;
  } result_t;

  function automatic logic slot_in_range(input logic [SLOT_W-1:0] slot);
    return 32'(slot) < 32'(SLOTS);
  endfunction

  function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] slot);
    logic [31:0] wide;
    wide = 32'(slot);
    return wide[IDX_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// File: rtl/icu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module icu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/icu_exec.sv
// Action logic: turns a request and its target entry into a write-back and a result.
module icu_exec import icu_pkg::*; (
  input  req_t             req_i,
  input  entry_t           ent_i,
  input  logic [IDX_W-1:0] tgt_i,
  input  scan_t            scan_i,
  output wr_t              wr_o,
  output result_t          res_o
);

  logic zero_rep;

  always_comb begin
    wr_o             = '0;
    wr_o.idx         = slot_to_idx(req_i.slot);
    wr_o.ent         = ent_i;
    res_o            = '0;
    res_o.status     = ST_IGNORED;
    res_o.result_slot = req_i.slot;
    zero_rep         = 1'b0;

    if (req_i.action == ACT_GET) begin
      wr_o.idx          = tgt_i;
      res_o.result_slot = idx_to_slot(tgt_i);
      if (scan_i.found) begin
        res_o.hit = 1'b1;
        if (ent_i.refcnt == REF_MAX) begin
          res_o.status = ST_OVERFLOW;
        end else begin
          wr_o.we         = 1'b1;
          wr_o.ent.refcnt = ent_i.refcnt + REF_ONE;
          res_o.status    = ST_OK;
        end
      end else if (scan_i.free_seen) begin
        // claim the lowest free slot
        wr_o.we         = 1'b1;
        wr_o.ent.refcnt = REF_ONE;
        wr_o.ent.device = req_i.device;
        wr_o.ent.inode  = req_i.inode;
        wr_o.ent.valid  = 1'b0;
        wr_o.ent.busy   = 1'b0;
        res_o.status    = ST_OK;
      end else begin
        res_o.status      = ST_FULL;
        res_o.result_slot = '0;
        zero_rep          = 1'b1;
      end
    end else if (!slot_in_range(req_i.slot)) begin
      zero_rep = 1'b1;
    end else begin
      case (req_i.action)
        ACT_DUP: begin
          if (ent_i.refcnt == REF_ZERO) begin
            res_o.status = ST_IGNORED;
          end else if (ent_i.busy) begin
            res_o.status = ST_BUSY;
          end else if (ent_i.refcnt == REF_MAX) begin
            res_o.status = ST_OVERFLOW;
          end else begin
            wr_o.we         = 1'b1;
            wr_o.ent.refcnt = ent_i.refcnt + REF_ONE;
            res_o.status    = ST_OK;
          end
        end
        ACT_PUT: begin
          if (ent_i.refcnt == REF_ZERO) begin
            res_o.status = ST_IGNORED;
          end else if (ent_i.refcnt == REF_ONE && ent_i.valid) begin
            if (ent_i.busy) begin
              res_o.status = ST_BUSY;
            end else begin
              // last release of a loaded slot
              wr_o.we                 = 1'b1;
              wr_o.ent.refcnt         = REF_ZERO;
              wr_o.ent.valid          = 1'b0;
              wr_o.ent.busy           = 1'b0;
              res_o.writeback_request = 1'b1;
              res_o.status            = ST_OK;
            end
          end else begin
            wr_o.we         = 1'b1;
            wr_o.ent.refcnt = ent_i.refcnt - REF_ONE;
            res_o.status    = ST_OK;
          end
        end
        ACT_LOCK: begin
          if (ent_i.refcnt == REF_ZERO) begin
            res_o.status = ST_IGNORED;
          end else if (ent_i.busy) begin
            res_o.status = ST_BUSY;
          end else begin
            wr_o.we       = 1'b1;
            wr_o.ent.busy = 1'b1;
            if (!ent_i.valid) begin
              res_o.load_request = 1'b1;
              wr_o.ent.valid     = 1'b1;
            end
            res_o.status = ST_OK;
          end
        end
        ACT_UNLOCK: begin
          if (ent_i.refcnt == REF_ZERO || !ent_i.busy) begin
            res_o.status = ST_IGNORED;
          end else begin
            wr_o.we       = 1'b1;
            wr_o.ent.busy = 1'b0;
            res_o.wake    = 1'b1;
            res_o.status  = ST_OK;
          end
        end
        default: begin
          res_o.status = ST_IGNORED;
        end
      endcase
    end

    res_o.slot_device = zero_rep ? '0 : wr_o.ent.device;
    res_o.slot_inode  = zero_rep ? '0 : wr_o.ent.inode;
  end

endmodule

// File: rtl/inode_reference_cache_unit.sv
// Top level of the inode reference cache: sequencer, slot table and result register.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+---------------------------------
//  request  | in  | s_axis_tvalid / s_axis_tready | s_axis_tdata: action, device,
//           |     |                              |   inode_number, slot
//  result   | out | m_axis_tvalid / m_axis_tready | m_axis_tdata: status, result_slot,
//           |     |                              |   hit, load/writeback/wake, slot
//           |     |                              |   device, slot inode
//
// Sequence: a get walks the slot table once through the single read port of the
// table RAM, one slot a cycle, and stops early on a hit. Dup, put, lock and unlock
// go through read, capture and execute; a slot outside the table goes straight to
// execute.
// Reset: rst_ni clears the sequencer state, the result valid flag and one live bit per
// slot; a slot whose live bit is low reads as all zero, so no clearing pass runs.
// Stalls: one request is in flight at a time. A finished result sits in the output
// register while the next request is taken; execute waits only when that register
// is still full and m_axis_tready is low.
`include "assert_macros.svh"

module inode_reference_cache_unit import icu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] action, [10:3] device, [42:11] inode_number, [47:43] slot
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [7:3] result_slot, [8] hit, [9] load_request,
  // [10] writeback_request, [11] wake, [19:12] slot_device, [51:20] slot_inode,
  // [55:52] zero
  output logic [55:0] m_axis_tdata
);

  // Sequencer state
  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;            // next slot to read during a scan
  logic             issue_done_q, issue_done_d;
  logic             pend_q, pend_d;          // read data of eval_idx is on the RAM port
  logic             found_q, found_d;
  logic             free_seen_q, free_seen_d;
  logic             rd_live_q;

  // Request payload and scan results
  req_t             req_q, req_d;
  entry_t           ent_q, ent_d;
  logic [IDX_W-1:0] eval_idx_q, eval_idx_d;
  logic [IDX_W-1:0] tgt_q, tgt_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;

  // Slot table: one live bit per slot, contents in RAM
  logic [SLOTS-1:0]     live_q;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t               rd_entry;
  logic                 ram_we;

  // Result register
  logic    m_valid_q;
  result_t res_q;
  logic    out_load;
  logic    out_free;

  // Execute stage
  wr_t     wr;
  result_t res;
  scan_t   scan;
  logic    scan_match;

  icu_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr.idx),
    .wdata_i (wr.ent),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Never-written slots read as the reset value.
  assign rd_entry = rd_live_q ? entry_t'(ram_rdata) : '0;

  assign scan_match = (rd_entry.refcnt != REF_ZERO) &&
                      (rd_entry.device == req_q.device) &&
                      (rd_entry.inode == req_q.inode);

  assign scan.found     = found_q;
  assign scan.free_seen = free_seen_q;

  icu_exec u_exec (
    .req_i  (req_q),
    .ent_i  (ent_q),
    .tgt_i  (found_q ? tgt_q : free_idx_q),
    .scan_i (scan),
    .wr_o   (wr),
    .res_o  (res)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SQ_IDLE;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      free_seen_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      issue_done_q <= issue_done_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      free_seen_q  <= free_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ent_q      <= ent_d;
    eval_idx_q <= eval_idx_d;
    tgt_q      <= tgt_d;
    free_idx_q <= free_idx_d;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    pend_d       = 1'b0;
    found_d      = found_q;
    free_seen_d  = free_seen_q;
    req_d        = req_q;
    ent_d        = ent_q;
    eval_idx_d   = eval_idx_q;
    tgt_d        = tgt_q;
    free_idx_d   = free_idx_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q;
    ram_we       = 1'b0;
    out_load     = 1'b0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      SQ_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d        = req_t'(s_axis_tdata);
          idx_d        = '0;
          issue_done_d = 1'b0;
          found_d      = 1'b0;
          free_seen_d  = 1'b0;
          if (req_d.action == ACT_GET) begin
            state_d = SQ_SCAN;
          end else if (slot_in_range(req_d.slot)) begin
            state_d = SQ_READ;
          end else begin
            state_d = SQ_EXEC;
          end
        end
      end
      SQ_SCAN: begin
        // issue one read a cycle, evaluate the one issued the cycle before
        if (!issue_done_q) begin
          rd_en        = 1'b1;
          idx_d        = idx_q + 1'b1;
          issue_done_d = (idx_q == LAST_IDX);
          eval_idx_d   = idx_q;
          pend_d       = 1'b1;
        end
        if (pend_q) begin
          if (scan_match) begin
            found_d = 1'b1;
            tgt_d   = eval_idx_q;
            ent_d   = rd_entry;
            state_d = SQ_EXEC;
          end else begin
            if (!free_seen_q && rd_entry.refcnt == REF_ZERO) begin
              free_seen_d = 1'b1;
              free_idx_d  = eval_idx_q;
            end
            if (eval_idx_q == LAST_IDX) begin
              state_d = SQ_EXEC;
            end
          end
        end
      end
      SQ_READ: begin
        rd_en   = 1'b1;
        rd_addr = slot_to_idx(req_q.slot);
        state_d = SQ_CAP;
      end
      SQ_CAP: begin
        ent_d   = rd_entry;
        state_d = SQ_EXEC;
      end
      SQ_EXEC: begin
        // write back and hand off together, once the result register is free
        if (out_free) begin
          ram_we   = wr.we;
          out_load = 1'b1;
          state_d  = SQ_IDLE;
        end
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      rd_live_q <= 1'b0;
    end else begin
      if (ram_we) begin
        live_q[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_live_q <= live_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.slot_inode, res_q.slot_device, res_q.wake,
                          res_q.writeback_request, res_q.load_request, res_q.hit,
                          res_q.result_slot, res_q.status};

  // Write-back and table reads never share a cycle.
  `ASSERT_NEVER(a_wr_rd_excl, clk_i, rst_ni, ram_we && rd_en, "table write during read")
  // An accepted request always leaves idle.
  `ASSERT_PROP(a_leave_idle, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> (state_q != SQ_IDLE), "request accepted but sequencer idle")
  // A written slot is live from then on.
  `ASSERT_PROP(a_live_set, clk_i, rst_ni, ram_we |=> live_q[$past(wr.idx)], "written slot not marked live")

endmodule
